// ----- hdl/dse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dse_pkg
// Shared types and codes for the descriptive statistics engine.
// ----------------------------------------------------------------------------
package dse_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_MEAN,
		ST_MED,
		ST_RNG,
		ST_MODE
	} state_t;

	localparam logic [2:0] SEL_MEAN   = 3'd0;
	localparam logic [2:0] SEL_MEDIAN = 3'd1;
	localparam logic [2:0] SEL_RANGE  = 3'd2;
	localparam logic [2:0] SEL_MODE   = 3'd3;
	localparam logic [2:0] SEL_ALL    = 3'd4;

	localparam logic [1:0] KIND_MEAN   = 2'd0;
	localparam logic [1:0] KIND_MEDIAN = 2'd1;
	localparam logic [1:0] KIND_RANGE  = 2'd2;
	localparam logic [1:0] KIND_MODE   = 2'd3;

	localparam int VALUE_W = 33;

endpackage

// ----- hdl/dse_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dse_cell
// One slot of the sorted sample chain: insertion step or rotate step.
// ----------------------------------------------------------------------------
module dse_cell #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                ins_en,
	input  logic                shift_en,
	input  logic signed [W-1:0] s,
	input  logic                valid,
	input  logic                prev_valid,
	input  logic                prev_gt,
	input  logic signed [W-1:0] prev_v,
	input  logic signed [W-1:0] next_v,
	output logic                gt,
	output logic signed [W-1:0] v
);

	logic signed [W-1:0] v_q;

	assign gt = valid && (v_q > s);
	assign v  = v_q;

	always_ff @(posedge clk) begin
		if (ins_en) begin
			// larger values move up one slot, the new sample lands at the boundary
			if (prev_gt) begin
				v_q <= prev_v;
			end else if (gt || (!valid && prev_valid)) begin
				v_q <= s;
			end
		end else if (shift_en) begin
			v_q <= next_v;
		end
	end

endmodule

// ----- hdl/dse_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dse_div
// Restoring signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module dse_div #(
	parameter int NW = 37,
	parameter int DW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] dividend,
	input  logic [DW-1:0]        divisor,
	output logic                 done,
	output logic signed [NW-1:0] quotient
);

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   mag_q;
	logic [DW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic            neg_q;
	logic [DW:0]     rem_next;
	logic [DW:0]     rem_sub;

	assign rem_next = {rem_q, mag_q[NW-1]};
	assign rem_sub  = rem_next - {1'b0, divisor};
	assign done     = done_q;
	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == CNTW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
			neg_q <= dividend[NW-1];
			rem_q <= '0;
			cnt_q <= CNTW'(NW);
		end else if (run_q) begin
			if (rem_next >= {1'b0, divisor}) begin
				rem_q <= rem_sub[DW-1:0];
				mag_q <= {mag_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_next[DW-1:0];
				mag_q <= {mag_q[NW-2:0], 1'b0};
			end
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

endmodule

// ----- hdl/descriptive_statistics_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptive_statistics_engine
// Sorted sample chain with mean, median, range and mode readout.
// ----------------------------------------------------------------------------
// Samples: one per cycle while not busy, each inserted into the cell chain on acceptance.
// After the last sample: a divide for the mean, a rotation of the chain for
// min/max/median/mode counts, then one cycle per scalar result and a second
// rotation for the mode pass.
// Results are strobed for one cycle; the receiver cannot stall.
// Async reset clears the count, sum, flags and selector; cell data is not reset.
module descriptive_statistics_engine #(
	parameter int MAX_SAMPLES  = 32,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] sample,
	input  logic               last_sample,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_wdata,
	output logic               result_valid,
	output logic [1:0]         result_kind,
	output logic signed [32:0] value,
	output logic               last_result,
	output logic               overflow_flag
);

	localparam int W    = SAMPLE_WIDTH;
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int JW   = $clog2(MAX_SAMPLES);
	localparam int SUMW = W + CW;

	dse_pkg::state_t state_q, state_d;

	logic [2:0]             sel_q;
	logic [2:0]             sel;
	logic [CW-1:0]          count_q;
	logic signed [SUMW-1:0] sum_q;
	logic                   drop_q;
	logic                   div_go_q;
	logic [JW-1:0]          j_q;
	logic [CW-1:0]          run_q, best_q, nbest_q, mcnt_q;
	logic signed [W-1:0]    prev_q, min_q, max_q, lo_q, hi_q;
	logic signed [SUMW-1:0] mean_q;

	logic signed [63:0]     s_ext;
	logic signed [W-1:0]    s;
	logic                   accept, room, ins_en, shift_en;
	logic                   scan_end, in_set, run_start, run_end, mode_hit, finish;
	logic [CW-1:0]          j_ext, run_cur;
	logic                   div_done;
	logic signed [SUMW-1:0] quot;

	logic signed [W-1:0] cv [MAX_SAMPLES];
	logic                cgt [MAX_SAMPLES];
	logic                cvalid [MAX_SAMPLES];

	logic                emit, emit_last;
	logic [1:0]          emit_kind;
	logic signed [63:0]  emit_val;
	logic signed [W:0]   med_sum, rng;

	assign busy     = (state_q != dse_pkg::ST_IDLE);
	assign accept   = start && !busy;
	assign room     = (count_q < CW'(MAX_SAMPLES));
	assign ins_en   = accept && room;
	assign shift_en = (state_q == dse_pkg::ST_SCAN) || (state_q == dse_pkg::ST_MODE);
	assign s_ext    = 64'(sample);
	assign s        = s_ext[W-1:0];
	assign sel      = (sel_q > dse_pkg::SEL_ALL) ? dse_pkg::SEL_ALL : sel_q;

	genvar i;
	generate
		for (i = 0; i < MAX_SAMPLES; i++) begin : g_cell
			assign cvalid[i] = (CW'(i) < count_q);
			dse_cell #(.W(W)) u_cell (
				.clk        (clk),
				.ins_en     (ins_en),
				.shift_en   (shift_en),
				.s          (s),
				.valid      (cvalid[i]),
				.prev_valid ((i == 0) ? 1'b1 : cvalid[(i == 0) ? 0 : i-1]),
				.prev_gt    ((i == 0) ? 1'b0 : cgt[(i == 0) ? 0 : i-1]),
				.prev_v     (cv[(i == 0) ? 0 : i-1]),
				.next_v     (cv[(i + 1) % MAX_SAMPLES]),
				.gt         (cgt[i]),
				.v          (cv[i])
			);
		end
	endgenerate

	dse_div #(.NW(SUMW), .DW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quot)
	);

	// run tracking over the rotating chain: cell 0 is the current element
	assign scan_end  = (j_q == JW'(MAX_SAMPLES - 1));
	assign j_ext     = CW'(j_q);
	assign in_set    = (j_ext < count_q);
	assign run_start = (j_q == '0) || (cv[0] != prev_q);
	assign run_cur   = run_start ? CW'(1) : run_q + CW'(1);
	assign run_end   = (j_ext + CW'(1) == count_q) || (cv[1] != cv[0]);
	assign mode_hit  = (state_q == dse_pkg::ST_MODE) && in_set && run_end
		&& (run_cur == best_q);
	assign med_sum   = (W+1)'(lo_q) + (W+1)'(hi_q);
	assign rng       = (W+1)'(max_q) - (W+1)'(min_q);

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_last = 1'b0;
		emit_kind = dse_pkg::KIND_MEAN;
		emit_val  = 64'(mean_q);
		finish    = 1'b0;
		unique case (state_q)
			dse_pkg::ST_IDLE: begin
				if (accept && last_sample) state_d = dse_pkg::ST_DIV;
			end
			dse_pkg::ST_DIV: begin
				if (div_done) state_d = dse_pkg::ST_SCAN;
			end
			dse_pkg::ST_SCAN: begin
				if (scan_end) begin
					unique case (sel)
						dse_pkg::SEL_MEDIAN: state_d = dse_pkg::ST_MED;
						dse_pkg::SEL_RANGE:  state_d = dse_pkg::ST_RNG;
						dse_pkg::SEL_MODE:   state_d = dse_pkg::ST_MODE;
						default:             state_d = dse_pkg::ST_MEAN;
					endcase
				end
			end
			dse_pkg::ST_MEAN: begin
				emit      = 1'b1;
				emit_last = (sel != dse_pkg::SEL_ALL);
				state_d   = emit_last ? dse_pkg::ST_IDLE : dse_pkg::ST_MED;
				finish    = emit_last;
			end
			dse_pkg::ST_MED: begin
				emit      = 1'b1;
				emit_kind = dse_pkg::KIND_MEDIAN;
				emit_val  = 64'(med_sum >>> 1);
				emit_last = (sel != dse_pkg::SEL_ALL);
				state_d   = emit_last ? dse_pkg::ST_IDLE : dse_pkg::ST_RNG;
				finish    = emit_last;
			end
			dse_pkg::ST_RNG: begin
				emit      = 1'b1;
				emit_kind = dse_pkg::KIND_RANGE;
				emit_val  = 64'(rng);
				emit_last = (sel != dse_pkg::SEL_ALL);
				state_d   = emit_last ? dse_pkg::ST_IDLE : dse_pkg::ST_MODE;
				finish    = emit_last;
			end
			dse_pkg::ST_MODE: begin
				emit      = mode_hit;
				emit_kind = dse_pkg::KIND_MODE;
				emit_val  = 64'(cv[0]);
				emit_last = (mcnt_q + CW'(1) == nbest_q);
				if (scan_end) begin
					state_d = dse_pkg::ST_IDLE;
					finish  = 1'b1;
				end
			end
			default: state_d = dse_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dse_pkg::ST_IDLE;
			sel_q        <= dse_pkg::SEL_MEAN;
			count_q      <= '0;
			sum_q        <= '0;
			drop_q       <= 1'b0;
			div_go_q     <= 1'b0;
			j_q          <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			div_go_q     <= accept && last_sample;
			result_valid <= emit;
			if (cfg_we) sel_q <= cfg_wdata;
			if (ins_en) begin
				count_q <= count_q + CW'(1);
				sum_q   <= sum_q + SUMW'(s);
			end else if (accept) begin
				drop_q <= 1'b1;
			end
			if (finish) begin
				count_q <= '0;
				sum_q   <= '0;
				drop_q  <= 1'b0;
			end
			if (shift_en) begin
				j_q <= scan_end ? '0 : j_q + JW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) mean_q <= quot;
		if (accept && last_sample) begin
			best_q  <= '0;
			nbest_q <= '0;
			mcnt_q  <= '0;
		end
		if (shift_en && in_set) begin
			run_q  <= run_cur;
			prev_q <= cv[0];
		end
		if (state_q == dse_pkg::ST_SCAN && in_set) begin
			if (j_q == '0) min_q <= cv[0];
			if (j_ext + CW'(1) == count_q) max_q <= cv[0];
			if (j_ext == ((count_q - CW'(1)) >> 1)) lo_q <= cv[0];
			if (j_ext == (count_q >> 1)) hi_q <= cv[0];
			if (run_end) begin
				if (run_cur > best_q) begin
					best_q  <= run_cur;
					nbest_q <= CW'(1);
				end else if (run_cur == best_q) begin
					nbest_q <= nbest_q + CW'(1);
				end
			end
		end
		if (mode_hit) mcnt_q <= mcnt_q + CW'(1);
		if (emit) begin
			result_kind   <= emit_kind;
			value         <= emit_val[32:0];
			last_result   <= emit_last;
			overflow_flag <= drop_q;
		end
	end

endmodule
